@@ sv/bci_pkg.sv @@
// ---------------------------------------------------------------------------
// Binned curve interpolator package
// Shared widths, codes, payload structs and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package bci_pkg;

   // Default curve geometry.
   localparam int POINTS_DEFAULT      = 25;
   localparam int RADIAL_BINS_DEFAULT = 5;

   // Field widths.
   localparam int RAD_W   = 13;
   localparam int MOM_W   = 14;
   localparam int EFF_W   = 16;
   localparam int BIN_W   = 3;
   localparam int PART_W  = 3;
   localparam int PIDX_W  = 5;
   localparam int PROD_W  = MOM_W + EFF_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 14;

   // Radius edges and the bins that are searched.
   localparam int EDGE_COUNT = 6;
   localparam int MAX_SEARCH_BINS = 5;

   // Request kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Particle codes.
   localparam logic [PART_W-1:0] PART_ELECTRON = 3'd0;
   localparam logic [PART_W-1:0] PART_GAMMA    = 3'd1;
   localparam logic [PART_W-1:0] PART_PION     = 3'd2;
   localparam logic [PART_W-1:0] PART_PROTON   = 3'd3;

   // Bin code for a radius outside every bin.
   localparam logic [BIN_W-1:0] NO_BIN = 3'd5;

   // Register indexes: edges occupy 0 to EDGE_COUNT-1.
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_FIRST = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF     = 3'd6;

   // Register reset values.
   localparam logic [RAD_W-1:0] EDGE_RESET [EDGE_COUNT] = '{
      13'd1760, 13'd1856, 13'd1984, 13'd2640, 13'd3280, 13'd4240
   };
   localparam logic [MOM_W-1:0] CUTOFF_RESET = 14'd512;

   typedef struct packed {
      logic              req_type;
      logic              phi_high;
      logic [PART_W-1:0] particle;
      logic [BIN_W-1:0]  load_bin;
      logic [PIDX_W-1:0] point_index;
      logic [MOM_W-1:0]  point_momentum;
      logic [EFF_W-1:0]  point_efficiency;
      logic [RAD_W-1:0]  hit_radius;
      logic [MOM_W-1:0]  hit_momentum;
   } req_payload_type;

   typedef struct packed {
      logic [EFF_W-1:0] efficiency;
      logic [BIN_W-1:0] radial_bin;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_MULT   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

`default_nettype wire

@@ sv/bci_divider.sv @@
// ---------------------------------------------------------------------------
// Binned curve interpolator divider
// Restoring divider, one quotient bit per cycle, for a quotient known to fit
// in EFF_W bits.
// ---------------------------------------------------------------------------
`default_nettype none

module bci_divider
   import bci_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [PROD_W-1:0] dividend,
   input  wire logic [MOM_W-1:0]  divisor,
   output logic                   done,
   output logic [EFF_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(EFF_W + 1);

   logic [MOM_W-1:0] rem_ff, rem_in;
   logic [EFF_W-1:0] low_ff, low_in;
   logic [EFF_W-1:0] quo_ff, quo_in;
   logic [MOM_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [MOM_W:0]   trial;
   logic             fits;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      trial = {rem_ff, low_ff[EFF_W-1]};
      fits  = (trial >= {1'b0, div_ff});
   end

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         // The upper part is already below the divisor, as the quotient fits.
         rem_in = dividend[PROD_W-1:EFF_W];
         low_in = dividend[EFF_W-1:0];
         div_in = divisor;
         cnt_in = CNT_W'(EFF_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? MOM_W'(trial - {1'b0, div_ff}) : trial[MOM_W-1:0];
         low_in  = {low_ff[EFF_W-2:0], 1'b0};
         quo_in  = {quo_ff[EFF_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ sv/binned_curve_interpolator_top.sv @@
// ---------------------------------------------------------------------------
// Binned curve interpolator
// Piecewise linear efficiency lookup over binned, loadable curves.
// ---------------------------------------------------------------------------
// A load request writes one curve point and produces no response. A query
// whose radius lies in a bin reads its curve one point per cycle from the
// curve memory, multiplies once and runs a sixteen-step serial divide; the
// point scan through the single memory read port and the divider set how
// long it occupies the block. A query outside every bin skips the scan and
// goes straight to the finish step. The request channel is not ready while
// a query is in progress, but a finished response may wait in the output
// register while the next request is taken. The curve memory is not cleared:
// each point must be loaded before it is queried.
`default_nettype none

module binned_curve_interpolator_top
   import bci_pkg::*;
#(
   parameter int POINTS      = POINTS_DEFAULT,
   parameter int RADIAL_BINS = RADIAL_BINS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_payload_type       req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_payload_type            rsp_payload,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH       = 4 * RADIAL_BINS * POINTS;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(POINTS + 1);
   localparam int SEARCH_BINS = (RADIAL_BINS < MAX_SEARCH_BINS) ? RADIAL_BINS
                                                                 : MAX_SEARCH_BINS;
   localparam int ENTRY_W     = MOM_W + EFF_W;

   // Configuration registers.
   logic [RAD_W-1:0] edge_ff [EDGE_COUNT];
   logic [MOM_W-1:0] cutoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < EDGE_COUNT; i++) begin
            edge_ff[i] <= EDGE_RESET[i];
         end
         cutoff_ff <= CUTOFF_RESET;
      end else if (csr_we) begin
         for (int i = 0; i < EDGE_COUNT; i++) begin
            if (csr_index == CSR_EDGE_FIRST + CSR_IDX_W'(i)) begin
               edge_ff[i] <= csr_wdata[RAD_W-1:0];
            end
         end
         if (csr_index == CSR_CUTOFF) begin
            cutoff_ff <= csr_wdata;
         end
      end
   end

   // Sequencer and per-query registers.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [MOM_W-1:0]  hmom_ff, hmom_in;
   logic [BIN_W-1:0]  bin_ff, bin_in;
   logic              proton_ff, proton_in;
   logic [MOM_W-1:0]  x0_ff, x0_in;
   logic [EFF_W-1:0]  e0_ff, e0_in;
   logic [MOM_W-1:0]  prev_x_ff, prev_x_in;
   logic [EFF_W-1:0]  prev_e_ff, prev_e_in;
   logic              seg_found_ff, seg_found_in;
   logic [MOM_W-1:0]  seg_xa_ff, seg_xa_in;
   logic [EFF_W-1:0]  seg_ea_ff, seg_ea_in;
   logic [EFF_W-1:0]  seg_eb_ff, seg_eb_in;
   logic [MOM_W-1:0]  seg_den_ff, seg_den_in;
   logic              neg_ff, neg_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              div_start_ff, div_start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   logic              req_xfer;
   logic              is_query;
   logic [BIN_W-1:0]  bin_sel;
   logic              cls_query;
   logic              load_ok;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [MOM_W-1:0]  rd_x;
   logic [EFF_W-1:0]  rd_e;
   logic              out_load;
   logic              div_done;
   logic [EFF_W-1:0]  div_quotient;
   logic [EFF_W:0]    interp_sum;
   logic [EFF_W-1:0]  interp_eff;
   logic [EFF_W-1:0]  final_eff;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign is_query  = (req_payload.req_type == REQ_QUERY);

   // Radial bin search; the highest matching bin wins.
   always_comb begin
      bin_sel = NO_BIN;
      for (int i = 0; i < SEARCH_BINS; i++) begin
         if (req_payload.hit_radius > edge_ff[i] &&
             req_payload.hit_radius <= edge_ff[i + 1]) begin
            bin_sel = BIN_W'(i);
         end
      end
   end

   // Pion and proton queries use the pion curves; everything else the electron ones.
   assign cls_query = (req_payload.particle == PART_PION) ||
                      (req_payload.particle == PART_PROTON);

   // Load address decode and validity.
   assign load_ok = ((req_payload.particle == PART_ELECTRON) ||
                     (req_payload.particle == PART_PION)) &&
                    (32'(req_payload.load_bin) < RADIAL_BINS) &&
                    (32'(req_payload.point_index) < POINTS);
   assign wr_addr = ADDR_W'((32'({req_payload.phi_high,
                                  req_payload.particle == PART_PION}) * RADIAL_BINS
                             + 32'(req_payload.load_bin)) * POINTS
                            + 32'(req_payload.point_index));

   // Curve memory: momentum in the upper bits, efficiency in the lower.
   logic [ENTRY_W-1:0] curve_mem_ff [DEPTH];

   assign rd_en   = (state_ff == ST_SCAN) && (cnt_ff != CNT_W'(POINTS));
   assign rd_addr = base_ff + ADDR_W'(cnt_ff);

   always_ff @(posedge clock) begin
      if (req_xfer && !is_query && load_ok) begin
         curve_mem_ff[wr_addr] <= {req_payload.point_momentum,
                                   req_payload.point_efficiency};
      end
      if (rd_en) begin
         rd_data_ff <= curve_mem_ff[rd_addr];
      end
   end

   assign rd_x = rd_data_ff[ENTRY_W-1:EFF_W];
   assign rd_e = rd_data_ff[EFF_W-1:0];

   // Serial divider for the interpolation step.
   bci_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (prod_ff),
      .divisor  (seg_den_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Result selection from the scanned curve and the quotient.
   always_comb begin
      interp_sum = neg_ff ? ({1'b0, seg_ea_ff} - {1'b0, div_quotient})
                          : ({1'b0, seg_ea_ff} + {1'b0, div_quotient});
      if (!seg_found_ff) begin
         interp_eff = '0;
      end else if (interp_sum[EFF_W]) begin
         interp_eff = neg_ff ? '0 : '1;
      end else begin
         interp_eff = interp_sum[EFF_W-1:0];
      end
      final_eff = interp_eff;
      if (hmom_ff < x0_ff) begin
         final_eff = (hmom_ff < cutoff_ff) ? '0 : (e0_ff >> 1);
      end else if (hmom_ff == x0_ff) begin
         final_eff = e0_ff;
      end
      if (hmom_ff > prev_x_ff) begin
         final_eff = prev_e_ff;
      end
      if (bin_ff == NO_BIN) begin
         final_eff = '0;
      end
      if (proton_ff) begin
         final_eff = final_eff >> 1;
      end
   end

   assign out_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Sequencer next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      hmom_in      = hmom_ff;
      bin_in       = bin_ff;
      proton_in    = proton_ff;
      x0_in        = x0_ff;
      e0_in        = e0_ff;
      prev_x_in    = prev_x_ff;
      prev_e_in    = prev_e_ff;
      seg_found_in = seg_found_ff;
      seg_xa_in    = seg_xa_ff;
      seg_ea_in    = seg_ea_ff;
      seg_eb_in    = seg_eb_ff;
      seg_den_in   = seg_den_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      div_start_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && is_query) begin
               hmom_in      = req_payload.hit_momentum;
               bin_in       = bin_sel;
               proton_in    = (req_payload.particle == PART_PROTON);
               base_in      = ADDR_W'((32'({req_payload.phi_high, cls_query})
                                       * RADIAL_BINS + 32'(bin_sel)) * POINTS);
               cnt_in       = '0;
               seg_found_in = 1'b0;
               state_in     = (bin_sel == NO_BIN) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Point cnt-1 arrives from the memory while point cnt is read.
            if (cnt_ff != '0) begin
               if (cnt_ff == CNT_W'(1)) begin
                  x0_in = rd_x;
                  e0_in = rd_e;
               end else if (hmom_ff > prev_x_ff && hmom_ff <= rd_x) begin
                  seg_found_in = 1'b1;
                  seg_xa_in    = prev_x_ff;
                  seg_ea_in    = prev_e_ff;
                  seg_eb_in    = rd_e;
                  seg_den_in   = rd_x - prev_x_ff;
               end
               prev_x_in = rd_x;
               prev_e_in = rd_e;
            end
            if (cnt_ff == CNT_W'(POINTS)) begin
               state_in = seg_found_in ? ST_MULT : ST_FINISH;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_MULT: begin
            neg_in       = (seg_eb_ff < seg_ea_ff);
            prod_in      = PROD_W'(neg_in ? (seg_ea_ff - seg_eb_ff) : (seg_eb_ff - seg_ea_ff))
                           * PROD_W'(hmom_ff - seg_xa_ff);
            div_start_in = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: a finished response waits here until it is taken.
   always_comb begin
      rsp_valid_in   = out_load || (rsp_valid_ff && !rsp_ready);
      rsp_payload_in = rsp_payload_ff;
      if (out_load) begin
         rsp_payload_in.efficiency = final_eff;
         rsp_payload_in.radial_bin = bin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff        <= base_in;
      hmom_ff        <= hmom_in;
      bin_ff         <= bin_in;
      proton_ff      <= proton_in;
      x0_ff          <= x0_in;
      e0_ff          <= e0_in;
      prev_x_ff      <= prev_x_in;
      prev_e_ff      <= prev_e_in;
      seg_found_ff   <= seg_found_in;
      seg_xa_ff      <= seg_xa_in;
      seg_ea_ff      <= seg_ea_in;
      seg_eb_ff      <= seg_eb_in;
      seg_den_ff     <= seg_den_in;
      neg_ff         <= neg_in;
      prod_ff        <= prod_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The divider finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide step");

   // The scan counter never runs past the last point.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cnt_ff <= CNT_W'(POINTS))
      else $error("scan counter out of range");

   // A new response is only ever loaded from the finish step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish step");

   // A radius outside every bin gives zero efficiency.
   assert property (@(posedge clock) disable iff (reset)
      out_load && bin_ff == NO_BIN |=> rsp_payload_ff.efficiency == '0)
      else $error("out-of-range radius gave non-zero efficiency");

   // Proton results are halved, so their top bit is clear.
   assert property (@(posedge clock) disable iff (reset)
      out_load && proton_ff |=> rsp_payload_ff.efficiency[EFF_W-1] == 1'b0)
      else $error("proton result not halved");

endmodule

`default_nettype wire
